/* design/itt_pkg.sv */
// Shared types, codes and helpers for the indent token tracker.
`timescale 1ns / 1ps

package itt_pkg;

  // Sizing of the level stack and of a stored column.
  localparam int STACK_DEPTH = 32;
  localparam int COLUMN_BITS = 16;
  localparam int IDX_BITS    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);

  typedef logic [COLUMN_BITS-1:0] col_t;
  typedef logic [IDX_BITS-1:0]    idx_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  // Input command codes.
  localparam logic [1:0] CMD_CHAR  = 2'd0;
  localparam logic [1:0] CMD_LIMIT = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;

  // Character classes.
  localparam logic [1:0] CLS_NEWLINE = 2'd0;
  localparam logic [1:0] CLS_EOF     = 2'd1;

  // Token kinds.
  typedef enum logic [1:0] {
    KIND_IN  = 2'd0,
    KIND_OUT = 2'd1,
    KIND_ERR = 2'd2,
    KIND_OVF = 2'd3
  } token_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        idle;
    logic        idx_dec;
    logic        push;
    logic        pop;
    logic        emit;
    token_kind_t emit_kind;
    logic        emit_last;
  } itt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic start_char;
    logic start_eof;
    logic gt;
    logic lt;
    logic idx_zero;
    logic full;
    logic out_free;
    logic pop_last;
  } itt_sts_t;

  // Reduce a 16-bit input column to the stored column width.
  function automatic col_t to_col(logic [15:0] c);
    logic [COLUMN_BITS+15:0] w;
    w = {{COLUMN_BITS{1'b0}}, c};
    return w[COLUMN_BITS-1:0];
  endfunction

  // Widen or cut a stored column to the 16-bit token column.
  function automatic logic [15:0] from_col(col_t c);
    logic [COLUMN_BITS+15:0] w;
    w = {16'b0, c};
    return w[15:0];
  endfunction

endpackage

/* design/itt_in_if.sv */
// Input item channel of the indent token tracker.
`timescale 1ns / 1ps

interface itt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  char_class;
  logic [15:0] column;

  modport source (output valid, output cmd, output char_class, output column, input ready);
  modport sink   (input valid, input cmd, input char_class, input column, output ready);
endinterface

/* design/itt_out_if.sv */
// Token output channel of the indent token tracker.
`timescale 1ns / 1ps

interface itt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [15:0] token_column;
  logic        last;

  modport source (output valid, output token_kind, output token_column, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_column, input last,
                  output ready);
endinterface

/* design/itt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module itt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/itt_datapath.sv */
// Datapath of the indent token tracker: line state, level stack and token register.
`timescale 1ns / 1ps

module itt_datapath
  import itt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  itt_cmd_t    cmd,
  output itt_sts_t    sts,
  input  logic        item_valid,
  input  logic [1:0]  item_cmd,
  input  logic [1:0]  char_class,
  input  logic [15:0] column,
  input  logic        token_ready,
  output logic        token_valid,
  output logic [1:0]  token_kind,
  output logic [15:0] token_column,
  output logic        last
);

  cnt_t  count;
  logic  at_line_start;
  logic  limit_active;
  col_t  limit_column;
  col_t  col;
  idx_t  idx;
  idx_t  idx_next;
  col_t  entry;
  col_t  rdata;
  col_t  in_col;
  cnt_t  count_m1;
  logic  take;
  logic  act_char;
  logic  act_eof;

  assign in_col   = to_col(column);
  assign take     = cmd.idle && item_valid;
  assign count_m1 = count - cnt_t'(1);

  // Decode of the incoming item against the line state.
  always_comb begin
    act_char = (item_cmd == CMD_CHAR) && at_line_start &&
               (char_class != CLS_NEWLINE) && (char_class != CLS_EOF) &&
               !(limit_active && (in_col >= limit_column));
    act_eof  = (item_cmd == CMD_CHAR) && at_line_start &&
               (char_class == CLS_EOF) && (count > cnt_t'(1));
  end

  // Search index; the stack read address follows its next value.
  always_comb begin
    idx_next = idx;
    if (take && act_char) begin
      idx_next = count_m1[IDX_BITS-1:0];
    end else if (take && act_eof) begin
      idx_next = '0;
    end else if (cmd.idx_dec) begin
      idx_next = idx - idx_t'(1);
    end
  end

  itt_ram #(
    .WIDTH (COLUMN_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count[IDX_BITS-1:0]),
    .wdata (col),
    .raddr (idx_next),
    .rdata (rdata)
  );

  // The bottom level is always column zero.
  assign entry = (idx == '0) ? '0 : rdata;

  // Status toward the controller.
  always_comb begin
    sts.start_char = take && act_char;
    sts.start_eof  = take && act_eof;
    sts.gt         = col > entry;
    sts.lt         = col < entry;
    sts.idx_zero   = (idx == '0);
    sts.full       = (count == cnt_t'(STACK_DEPTH));
    sts.out_free   = !token_valid || token_ready;
    sts.pop_last   = (count == (cnt_t'(idx) + cnt_t'(2)));
  end

  // Line state, stack count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= cnt_t'(1);
      at_line_start <= 1'b1;
      limit_active  <= 1'b0;
      limit_column  <= '0;
      token_valid   <= 1'b0;
    end else begin
      if (take) begin
        if (item_cmd == CMD_LIMIT) begin
          limit_active <= 1'b1;
          limit_column <= in_col;
        end else if (item_cmd == CMD_MARK) begin
          at_line_start <= 1'b1;
        end else if (act_char) begin
          limit_active  <= 1'b0;
          at_line_start <= 1'b0;
        end
      end
      if (cmd.push) begin
        count <= count + cnt_t'(1);
      end else if (cmd.pop) begin
        count <= count - cnt_t'(1);
      end
      if (cmd.emit) begin
        token_valid <= 1'b1;
      end else if (token_ready) begin
        token_valid <= 1'b0;
      end
    end
  end

  // Payload registers: latched column, search index and token fields.
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (take) begin
      col <= in_col;
    end
    if (cmd.emit) begin
      token_kind   <= cmd.emit_kind;
      token_column <= from_col(col);
      last         <= cmd.emit_last;
    end
  end

endmodule

/* design/itt_ctrl.sv */
// Controller state machine of the indent token tracker.
`timescale 1ns / 1ps

module itt_ctrl
  import itt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  itt_sts_t sts,
  output itt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TOP,
    S_SEARCH,
    S_POP
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.emit_kind = KIND_IN;
    case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.start_char) begin
          state_next = S_TOP;
        end else if (sts.start_eof) begin
          state_next = S_POP;
        end
      end
      S_TOP: begin
        // Compare against the top level: indent or overflow, descend, or nothing on equal.
        if (sts.gt) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_kind = sts.full ? KIND_OVF : KIND_IN;
            cmd.push      = !sts.full;
            state_next    = S_IDLE;
          end
        end else if (sts.lt && !sts.idx_zero) begin
          cmd.idx_dec = 1'b1;
          state_next  = S_SEARCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SEARCH: begin
        // Walk down until the column is no longer below the level; a column above that level is an error.
        if (sts.lt && !sts.idx_zero) begin
          cmd.idx_dec = 1'b1;
        end else if (sts.gt) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            cmd.emit_kind = KIND_ERR;
            state_next    = S_IDLE;
          end
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        // One dedent token per level above the search index.
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_OUT;
          cmd.emit_last = sts.pop_last;
          cmd.pop       = 1'b1;
          if (sts.pop_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/indent_token_tracker_top.sv */
// Indent token tracker: offside-rule indent and dedent token generator.
// An item that causes no work leaves the controller idle, so the block stays ready for the next item.
// A line-start character compares against the top level; a shallower one searches down the stack
// memory level by level, then emits an error or a dedent per popped level; each token waits for a
// free output register. End of file pops one level per dedent token. One item is in work at a time.
// Synchronous reset restores the bottom level and line state, with no clearing pass.
`timescale 1ns / 1ps

module indent_token_tracker_top
  import itt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  itt_in_if.sink    item,
  itt_out_if.source token
);

  itt_cmd_t cmd;
  itt_sts_t sts;

  itt_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  itt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item_valid   (item.valid),
    .item_cmd     (item.cmd),
    .char_class   (item.char_class),
    .column       (item.column),
    .token_ready  (token.ready),
    .token_valid  (token.valid),
    .token_kind   (token.token_kind),
    .token_column (token.token_column),
    .last         (token.last)
  );

  // Items are taken only while the controller is idle.
  assign item.ready = cmd.idle;

endmodule

/* tb/sv/indent_token_tracker_top_tb.sv */
// Self-checking testbench for the indent token tracker: directed lines, then random lines.
`timescale 1ns / 1ps

module indent_token_tracker_top_tb;
  import itt_pkg::*;

  // Character classes and a command that the package leaves unnamed.
  localparam logic [1:0] CLS_OTHER = 2'd2;
  localparam logic [1:0] CLS_SPARE = 2'd3;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 51;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    token_kind_t kind;
    logic [15:0] col;
    logic        last;
  } token_t;

  // Tracks the indentation levels and holds the tokens still owed by the block.
  class token_scoreboard;
    col_t   level_col[STACK_DEPTH];
    int     level_cnt;
    bit     line_armed;
    bit     limit_armed;
    col_t   limit_col;
    token_t pending_tokens[$];
    int     mismatches;
    int     tokens_seen;
    int     peak_levels;
    int     overflows;

    function new();
      foreach (level_col[i]) level_col[i] = '0;
      level_cnt   = 1;
      line_armed  = 1'b1;
      limit_armed = 1'b0;
      limit_col   = '0;
      mismatches  = 0;
      tokens_seen = 0;
      peak_levels = 1;
      overflows   = 0;
    endfunction

    function void queue_token(token_kind_t kind, col_t cv);
      token_t t;
      t.kind = kind;
      t.col  = 16'(cv);
      t.last = 1'b0;
      pending_tokens.push_back(t);
    endfunction

    function void flag_mismatch(string msg);
      if (mismatches < REPORT_LIMIT) $display("ERROR: %s", msg);
      mismatches++;
    endfunction

    // Updates the level stack for one accepted transfer and queues its tokens.
    function void note_item(logic [1:0] c, logic [1:0] k, logic [15:0] col_in);
      col_t cv;
      int   idx;
      int   queued;
      cv = col_t'(col_in);
      queued = pending_tokens.size();
      if (c == CMD_LIMIT) begin
        limit_armed = 1'b1;
        limit_col   = cv;
      end else if (c == CMD_MARK) begin
        line_armed = 1'b1;
      end else if (c == CMD_CHAR && line_armed && k != CLS_NEWLINE) begin
        if (k == CLS_EOF) begin
          // End of file unwinds every level above the bottom one.
          while (level_cnt > 1) begin
            queue_token(KIND_OUT, cv);
            level_cnt--;
          end
        end else if (!(limit_armed && cv >= limit_col)) begin
          limit_armed = 1'b0;
          line_armed  = 1'b0;
          if (cv > level_col[level_cnt-1]) begin
            if (level_cnt >= STACK_DEPTH) begin
              queue_token(KIND_OVF, cv);
              overflows++;
            end else begin
              level_col[level_cnt] = cv;
              level_cnt++;
              if (level_cnt > peak_levels) peak_levels = level_cnt;
              queue_token(KIND_IN, cv);
            end
          end else begin
            // Search down for a matching level; a column between levels is an error.
            idx = level_cnt - 1;
            while (idx > 0 && cv < level_col[idx]) idx--;
            if (cv > level_col[idx]) begin
              queue_token(KIND_ERR, cv);
            end else begin
              while (level_cnt - 1 > idx) begin
                queue_token(KIND_OUT, cv);
                level_cnt--;
              end
            end
          end
        end
      end
      if (pending_tokens.size() > queued) pending_tokens[pending_tokens.size()-1].last = 1'b1;
    endfunction

    // Compares one output transfer against the oldest owed token.
    function void check_token(logic [1:0] kind, logic [15:0] col, logic last);
      token_t want;
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        flag_mismatch($sformatf("unexpected token kind %0d column %0d last %0d",
                                kind, col, last));
      end else begin
        want = pending_tokens.pop_front();
        if (want.kind !== kind || want.col !== col || want.last !== last) begin
          flag_mismatch($sformatf(
            "token %0d: expected kind %0d column %0d last %0d, got kind %0d column %0d last %0d",
            tokens_seen, want.kind, want.col, want.last, kind, col, last));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   items_sent     = 0;
  int   counted_items  = 0;
  token_scoreboard sb;

  itt_in_if  item_ch ();
  itt_out_if token_ch ();

  indent_token_tracker_top uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .token (token_ch)
  );

  // Free-running 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    token_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Every token transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && token_ch.valid && token_ch.ready) begin
      sb.check_token(token_ch.token_kind, token_ch.token_column, token_ch.last);
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (token_ch.valid && token_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("indent_token_tracker_top: mismatch");
    $finish;
  end

  // Offers one item from a falling edge and returns at the falling edge after its transfer.
  task automatic send_item(input logic [1:0] c, input logic [1:0] k, input logic [15:0] col,
                           input bit counts);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid      = 1'b1;
    item_ch.cmd        = c;
    item_ch.char_class = k;
    item_ch.column     = col;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(c, k, col);
    items_sent++;
    if (counts) counted_items++;
    @(negedge clk);
    item_ch.valid = 1'b0;
  endtask

  // Holds the sender off until every owed token has arrived.
  task automatic wait_drained();
    item_ch.valid = 1'b0;
    while (sb.pending_tokens.size() != 0) @(negedge clk);
  endtask

  initial begin
    int phase;
    int top;
    int pick;
    int gap_at;
    int col;

    sb = new();
    rst                = 1'b1;
    item_ch.valid      = 1'b0;
    item_ch.cmd        = CMD_CHAR;
    item_ch.char_class = CLS_NEWLINE;
    item_ch.column     = '0;
    token_ch.ready     = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed lines: blank line, lone end of file, equal column, mid-line character.
    send_item(CMD_CHAR, CLS_NEWLINE, 16'hFFFF, 1);
    send_item(CMD_CHAR, CLS_EOF, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0005, 1);
    // Two indents, the second with the spare character class, then an indent error.
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0004, 1);
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_SPARE, 16'h0008, 1);
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0006, 1);
    // A limit blocks columns at and beyond it, then a shallower column dedents.
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_LIMIT, CLS_OTHER, 16'h000A, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h000A, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'hFFFF, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0004, 1);
    // Widest column, an unknown command, then a double dedent to the bottom.
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'hFFFF, 1);
    send_item(CMD_SPARE, CLS_SPARE, 16'hAAAA, 1);
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0000, 1);
    // End of file ignores a pending limit; the limit then blocks and is replaced.
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0003, 1);
    send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_LIMIT, CLS_NEWLINE, 16'h0000, 1);
    send_item(CMD_CHAR, CLS_EOF, 16'h5555, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0007, 1);
    send_item(CMD_LIMIT, CLS_OTHER, 16'hFFFF, 1);
    send_item(CMD_CHAR, CLS_OTHER, 16'h0007, 1);
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 74 : 0;
      recv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 10 : 0;

      if (phase == 0) begin
        // Climb from the bottom to a full stack, overflow it, then unwind it all at once.
        send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
        send_item(CMD_CHAR, CLS_EOF, 16'h0000, 1);
        send_item(CMD_LIMIT, CLS_OTHER, 16'hFFFF, 1);
        while (sb.level_cnt < STACK_DEPTH) begin
          send_item(CMD_MARK, 2'($urandom_range(3)), 16'($urandom), 1);
          send_item(CMD_CHAR, CLS_OTHER,
                    16'(int'(sb.level_col[sb.level_cnt-1]) + $urandom_range(1, 3)), 1);
        end
        send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
        send_item(CMD_CHAR, CLS_OTHER, 16'(int'(sb.level_col[sb.level_cnt-1]) + 1), 1);
        send_item(CMD_MARK, CLS_NEWLINE, 16'h0000, 1);
        send_item(CMD_CHAR, CLS_EOF, 16'hFFFF, 1);
      end

      // Random lines: mostly well-formed, with some noise and end-of-file marks.
      counted_items = 0;
      while (counted_items < RANDOM_ITEMS / 3) begin
        send_item(CMD_MARK, 2'($urandom_range(3)), 16'($urandom), 1);
        pick = $urandom_range(99);
        if (pick < 6) begin
          send_item(2'($urandom_range(3)), 2'($urandom_range(3)), 16'($urandom), 1);
        end else if (pick < 14) begin
          send_item(CMD_CHAR, CLS_EOF, 16'($urandom), 1);
        end else begin
          top = sb.level_col[sb.level_cnt-1];
          if ($urandom_range(99) < 15) send_item(CMD_CHAR, CLS_NEWLINE, 16'($urandom), 0);
          if ($urandom_range(99) < 15) begin
            send_item(CMD_LIMIT, 2'($urandom_range(3)), 16'(top + $urandom_range(0, 6)), 1);
          end
          // Pick a deeper column, an existing level, a gap between levels, or anything.
          pick = $urandom_range(99);
          if (pick < 40) begin
            col = (top <= 65531) ? top + $urandom_range(1, 4) : $urandom_range(65535);
          end else if (pick < 75) begin
            col = sb.level_col[$urandom_range(sb.level_cnt - 1)];
          end else if (pick < 90) begin
            gap_at = -1;
            for (int i = 0; i + 1 < sb.level_cnt; i++) begin
              if (int'(sb.level_col[i+1]) - int'(sb.level_col[i]) > 1 &&
                  (gap_at < 0 || $urandom_range(1) == 1)) gap_at = i;
            end
            if (gap_at < 0) col = $urandom_range(65535);
            else col = int'(sb.level_col[gap_at]) + $urandom_range(1,
                       int'(sb.level_col[gap_at+1]) - int'(sb.level_col[gap_at]) - 1);
          end else begin
            col = $urandom_range(65535);
          end
          send_item(CMD_CHAR, ($urandom_range(99) < 85) ? CLS_OTHER : CLS_SPARE, 16'(col), 1);
          repeat ($urandom_range(2)) begin
            send_item(CMD_CHAR, 2'($urandom_range(3)), 16'($urandom), 0);
          end
        end
      end
      wait_drained();
    end

    // Let any work that owes no token finish, then report.
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("Run covered %0d transfers in, %0d tokens out, over three idle/stall mixes.",
             items_sent, sb.tokens_seen);
    $display("Stack peaked at %0d levels with %0d overflow tokens; %0d mismatches.",
             sb.peak_levels, sb.overflows, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_tokens.size() == 0) begin
      $display("indent_token_tracker_top: match");
    end else begin
      $display("indent_token_tracker_top: mismatch");
    end
    $finish;
  end

endmodule
